FILE: rtl/prac_pkg.sv
// Shared constants and the arctangent table for the point rotation pipeline.
`timescale 1ns / 1ps

package prac_pkg;

  // Default sizes.
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Sine/cosine carry 30 fraction bits; the phase is a 32-bit fraction of a turn.
  localparam int SC_FRAC    = 30;
  localparam int PHASE_W    = 32;
  localparam int XY_W       = 33;
  localparam int Z_W        = 34;
  localparam int GAIN_INV   = 652032874;

  // arctan(2^-k) in units of 2^-32 turn, rounded to nearest.
  function automatic logic [PHASE_W-1:0] atan_phase(input logic [4:0] k);
    logic [PHASE_W-1:0] a;
    unique case (k)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/point_rotate_about_center_unit.sv
// Top level: rotates a Q12.12 point about a center with a pipelined CORDIC.
`timescale 1ns / 1ps

// Rotates (point_x, point_y) about (center_x, center_y) by turn_angle
// (2^ANGLE_WIDTH units per turn, counterclockwise positive). A request is taken
// on every clock edge where start is high and busy is low; busy is high only
// during reset, so one request per cycle is sustained. Each request yields one
// result, flagged by done for a single cycle, after it passes through one input
// stage, one stage per CORDIC micro-rotation, a product stage, two summing and
// rounding stages and an output stage with the center add and clamp. Results
// come out in request order and cannot be held off, so the receiver must take
// each one in its done cycle. saturated marks a result where either coordinate
// was clamped to the coordinate range.
module point_rotate_about_center_unit #(
  parameter int COORD_WIDTH   = prac_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = prac_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = prac_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic                          saturated
);

  localparam int XY_W = prac_pkg::XY_W;
  localparam int Z_W  = prac_pkg::Z_W;
  localparam int DW   = COORD_WIDTH + 1;          // offset width
  localparam int SPL  = (COORD_WIDTH + 2) / 2;    // low part of the offset
  localparam int HW   = DW - SPL;                 // high part of the offset
  localparam int PL   = SPL + 1 + XY_W;           // low product width
  localparam int PH   = HW + XY_W;                // high product width
  localparam int SW   = DW + XY_W + 1;            // full dot product width
  localparam int RW   = COORD_WIDTH + 4;          // rounded dot product width
  localparam int NS   = CORDIC_STAGES;

  // ---------------- input stage ----------------
  logic [prac_pkg::PHASE_W-1:0] phase;
  logic                         flip;
  logic signed [XY_W-1:0]       x_init;
  logic signed [Z_W-1:0]        z_init;

  always_comb begin
    phase  = prac_pkg::PHASE_W'(unsigned'(turn_angle)) << (prac_pkg::PHASE_W - ANGLE_WIDTH);
    flip   = phase[prac_pkg::PHASE_W-1] ^ phase[prac_pkg::PHASE_W-2];
    x_init = flip ? -XY_W'(prac_pkg::GAIN_INV) : XY_W'(prac_pkg::GAIN_INV);
    // Second and third quarter: start from the negated vector, drop a half turn.
    z_init = Z_W'(signed'({phase[prac_pkg::PHASE_W-1] ^ flip,
                           phase[prac_pkg::PHASE_W-2:0]}));
  end

  assign busy = rst;

  // ---------------- CORDIC stages ----------------
  logic                          vld [0:NS];
  logic signed [XY_W-1:0]        cx_p [0:NS];
  logic signed [XY_W-1:0]        cy_p [0:NS];
  logic signed [Z_W-1:0]         cz_p [0:NS];
  logic signed [DW-1:0]          dx_p [0:NS];
  logic signed [DW-1:0]          dy_p [0:NS];
  logic signed [COORD_WIDTH-1:0] ox_p [0:NS];
  logic signed [COORD_WIDTH-1:0] oy_p [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    cx_p[0] <= x_init;
    cy_p[0] <= '0;
    cz_p[0] <= z_init;
    dx_p[0] <= DW'(point_x) - DW'(center_x);
    dy_p[0] <= DW'(point_y) - DW'(center_y);
    ox_p[0] <= center_x;
    oy_p[0] <= center_y;
  end

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [Z_W-1:0] atan_s;
    logic                  go_pos;

    assign atan_s = Z_W'(signed'({1'b0, prac_pkg::atan_phase(5'(i))}));
    assign go_pos = !cz_p[i][Z_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (go_pos) begin
        cx_p[i+1] <= cx_p[i] - (cy_p[i] >>> i);
        cy_p[i+1] <= cy_p[i] + (cx_p[i] >>> i);
        cz_p[i+1] <= cz_p[i] - atan_s;
      end else begin
        cx_p[i+1] <= cx_p[i] + (cy_p[i] >>> i);
        cy_p[i+1] <= cy_p[i] - (cx_p[i] >>> i);
        cz_p[i+1] <= cz_p[i] + atan_s;
      end
      dx_p[i+1] <= dx_p[i];
      dy_p[i+1] <= dy_p[i];
      ox_p[i+1] <= ox_p[i];
      oy_p[i+1] <= oy_p[i];
    end
  end

  // ---------------- product stage ----------------
  logic signed [SPL:0]  dxl, dyl;
  logic signed [HW-1:0] dxh, dyh;

  assign dxl = signed'({1'b0, dx_p[NS][SPL-1:0]});
  assign dyl = signed'({1'b0, dy_p[NS][SPL-1:0]});
  assign dxh = dx_p[NS][DW-1:SPL];
  assign dyh = dy_p[NS][DW-1:SPL];

  logic                          m1_vld;
  logic signed [PL-1:0]          xc_lo, ys_lo, xs_lo, yc_lo;
  logic signed [PH-1:0]          xc_hi, ys_hi, xs_hi, yc_hi;
  logic signed [COORD_WIDTH-1:0] m1_ox, m1_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    xc_lo <= PL'(dxl * cx_p[NS]);
    ys_lo <= PL'(dyl * cy_p[NS]);
    xs_lo <= PL'(dxl * cy_p[NS]);
    yc_lo <= PL'(dyl * cx_p[NS]);
    xc_hi <= PH'(dxh * cx_p[NS]);
    ys_hi <= PH'(dyh * cy_p[NS]);
    xs_hi <= PH'(dxh * cy_p[NS]);
    yc_hi <= PH'(dyh * cx_p[NS]);
    m1_ox <= ox_p[NS];
    m1_oy <= oy_p[NS];
  end

  // ---------------- partial sums ----------------
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (prac_pkg::SC_FRAC - 1);

  logic                          m2_vld;
  logic signed [SW-1:0]          rx_hi, rx_lo, ry_hi, ry_lo;
  logic signed [COORD_WIDTH-1:0] m2_ox, m2_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    rx_hi <= SW'(xc_hi) - SW'(ys_hi);
    ry_hi <= SW'(xs_hi) + SW'(yc_hi);
    rx_lo <= SW'(xc_lo) - SW'(ys_lo) + ROUND_HALF;
    ry_lo <= SW'(xs_lo) + SW'(yc_lo) + ROUND_HALF;
    m2_ox <= m1_ox;
    m2_oy <= m1_oy;
  end

  // ---------------- combine and round ----------------
  logic signed [SW-1:0] sum_x, sum_y, shr_x, shr_y;

  always_comb begin
    sum_x = (rx_hi <<< SPL) + rx_lo;
    sum_y = (ry_hi <<< SPL) + ry_lo;
    shr_x = sum_x >>> prac_pkg::SC_FRAC;
    shr_y = sum_y >>> prac_pkg::SC_FRAC;
  end

  logic                          m3_vld;
  logic signed [RW-1:0]          rnd_x, rnd_y;
  logic signed [COORD_WIDTH-1:0] m3_ox, m3_oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else begin
      m3_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    rnd_x <= shr_x[RW-1:0];
    rnd_y <= shr_y[RW-1:0];
    m3_ox <= m2_ox;
    m3_oy <= m2_oy;
  end

  // ---------------- center add and clamp ----------------
  logic signed [RW:0]            full_x, full_y;
  logic                          hit_x, hit_y;
  logic signed [COORD_WIDTH-1:0] clip_x, clip_y;

  always_comb begin
    full_x = (RW+1)'(rnd_x) + (RW+1)'(m3_ox);
    full_y = (RW+1)'(rnd_y) + (RW+1)'(m3_oy);
    // In range when every bit above the coordinate's sign bit copies it.
    hit_x  = !((&full_x[RW:COORD_WIDTH-1]) || !(|full_x[RW:COORD_WIDTH-1]));
    hit_y  = !((&full_y[RW:COORD_WIDTH-1]) || !(|full_y[RW:COORD_WIDTH-1]));
    clip_x = hit_x ? {full_x[RW], {(COORD_WIDTH-1){!full_x[RW]}}}
                   : full_x[COORD_WIDTH-1:0];
    clip_y = hit_y ? {full_y[RW], {(COORD_WIDTH-1){!full_y[RW]}}}
                   : full_y[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    rotated_x <= clip_x;
    rotated_y <= clip_y;
    saturated <= hit_x || hit_y;
  end

endmodule

FILE: rtl/prac_check.sv
// Port-level checks for the point rotation unit, bound to the top level.
`timescale 1ns / 1ps

module prac_check #(
  parameter int COORD_WIDTH   = prac_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = prac_pkg::ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = prac_pkg::CORDIC_STAGES_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [COORD_WIDTH-1:0] point_x,
  input logic signed [COORD_WIDTH-1:0] point_y,
  input logic signed [COORD_WIDTH-1:0] center_x,
  input logic signed [COORD_WIDTH-1:0] center_y,
  input logic signed [ANGLE_WIDTH-1:0] turn_angle,
  input logic                          done,
  input logic signed [COORD_WIDTH-1:0] rotated_x,
  input logic signed [COORD_WIDTH-1:0] rotated_y,
  input logic                          saturated
);

  localparam int LAT = CORDIC_STAGES + 5;

  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic took;
  logic same_spot;

  assign took      = start && !busy && !rst;
  assign same_spot = took && (point_x == center_x) && (point_y == center_y)
                     && (turn_angle == turn_angle);

  // Every request gives a result after the fixed latency.
  a_request_done: assert property (@(posedge clk) disable iff (rst)
    took |-> ##LAT done)
    else $error("request produced no result");

  // No result without a request that latency ago.
  a_done_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(took, LAT))
    else $error("result without request");

  // A clamp leaves a coordinate at an end of the range.
  a_sat_at_end: assert property (@(posedge clk) disable iff (rst)
    done && saturated |->
      (rotated_x == C_MAX) || (rotated_x == C_MIN) ||
      (rotated_y == C_MAX) || (rotated_y == C_MIN))
    else $error("saturated result not at a range end");

  // A point on the center stays on the center.
  a_center_fixed: assert property (@(posedge clk) disable iff (rst)
    done && $past(same_spot, LAT) |->
      (rotated_x == $past(center_x, LAT)) && (rotated_y == $past(center_y, LAT))
      && !saturated)
    else $error("center point moved");

endmodule

bind point_rotate_about_center_unit prac_check #(
  .COORD_WIDTH  (COORD_WIDTH),
  .ANGLE_WIDTH  (ANGLE_WIDTH),
  .CORDIC_STAGES(CORDIC_STAGES)
) u_prac_check (.*);

FILE: dv/tb_point_rotate_about_center_unit.sv
// Self-checking testbench for the point rotation unit with a CORDIC-based predictor.
`timescale 1ns / 1ps

module tb_point_rotate_about_center_unit;

  localparam int CW     = prac_pkg::COORD_WIDTH_DEF;
  localparam int AW     = prac_pkg::ANGLE_WIDTH_DEF;
  localparam int STAGES = prac_pkg::CORDIC_STAGES_DEF;

  localparam int    SINCOS_FRAC   = 30;
  localparam longint UNIT_GAIN_INV = 64'sd652032874;
  localparam longint COORD_MAX     = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint COORD_MIN     = -(64'sd1 <<< (CW - 1));
  localparam int    DRAIN_CYCLES  = STAGES + 20;
  localparam int    RANDOM_POINTS = 1700;
  localparam int    QUIET_TAIL    = 200;

  // arctan(2^-k) as a fraction of a turn, 2^32 units per turn
  localparam longint ATAN_TURN [0:31] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
    64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 sat;
  } rotated_point_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic signed [AW-1:0] turn_angle;
  logic                 done;
  logic signed [CW-1:0] rotated_x;
  logic signed [CW-1:0] rotated_y;
  logic                 saturated;

  rotated_point_t rotated_q[$];
  int             mismatch_count;

  point_rotate_about_center_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .point_x   (point_x),
    .point_y   (point_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .turn_angle(turn_angle),
    .done      (done),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .saturated (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [CW-1:0] clamp_coord(input longint v, inout logic clipped);
    if (v > COORD_MAX) begin
      clipped = 1'b1;
      return CW'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      clipped = 1'b1;
      return CW'(COORD_MIN);
    end
    return CW'(v);
  endfunction

  function automatic rotated_point_t rotate_about_center(
    input logic signed [CW-1:0] px, py, cx, cy,
    input logic signed [AW-1:0] ang
  );
    logic [31:0]    phase;
    longint         cs, sn, z, xs, ys;
    longint         dx, dy, cxl, cyl, acc_x, acc_y;
    logic           clipped;
    rotated_point_t r;
    phase = {ang, {(32 - AW){1'b0}}};
    cs = UNIT_GAIN_INV;
    sn = 0;
    // fold the second and third quarter turns onto the first and fourth
    if (phase[31:30] == 2'b01 || phase[31:30] == 2'b10) begin
      cs = -cs;
      phase[31] = ~phase[31];
    end
    z = $signed(phase);
    for (int i = 0; i < STAGES; i++) begin
      xs = cs >>> (i & 31);
      ys = sn >>> (i & 31);
      if (z >= 0) begin
        cs -= ys;
        sn += xs;
        z -= ATAN_TURN[i & 31];
      end else begin
        cs += ys;
        sn -= xs;
        z += ATAN_TURN[i & 31];
      end
    end
    cxl = cx;
    cyl = cy;
    dx = longint'(px) - cxl;
    dy = longint'(py) - cyl;
    // round half up, then add the center back
    acc_x = (dx * cs - dy * sn + (64'sd1 <<< (SINCOS_FRAC - 1))) >>> SINCOS_FRAC;
    acc_y = (dx * sn + dy * cs + (64'sd1 <<< (SINCOS_FRAC - 1))) >>> SINCOS_FRAC;
    clipped = 1'b0;
    r.x = clamp_coord(acc_x + cxl, clipped);
    r.y = clamp_coord(acc_y + cyl, clipped);
    r.sat = clipped;
    return r;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(input int kind);
    case (kind)
      0: return CW'($urandom_range(0, 131071)) - CW'(65536);
      1: return $urandom_range(0, 1) ? CW'(COORD_MAX - $urandom_range(0, 4095))
                                     : CW'(COORD_MIN + $urandom_range(0, 4095));
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_request(
    input logic signed [CW-1:0] px, py, cx, cy,
    input logic signed [AW-1:0] ang,
    input int gap
  );
    rotated_point_t expected;
    expected = rotate_about_center(px, py, cx, cy, ang);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    point_x    <= px;
    point_y    <= py;
    center_x   <= cx;
    center_y   <= cy;
    turn_angle <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    rotated_q = {rotated_q, expected};
  endtask

  task automatic test_angle_extremes();
    logic signed [AW-1:0] angles [11];
    angles = '{AW'(0), AW'(16384), AW'(-32768), AW'(-16384), AW'(32767), AW'(8192),
               AW'(16383), AW'(16385), AW'(-16385), AW'(-1), AW'(1)};
    foreach (angles[i]) send_request(CW'(4096), CW'(0), CW'(0), CW'(0), angles[i], 0);
  endtask

  task automatic test_coord_extremes();
    send_request(CW'(COORD_MAX), CW'(COORD_MAX), CW'(0), CW'(0), AW'(0), 0);
    send_request(CW'(COORD_MIN), CW'(COORD_MIN), CW'(0), CW'(0), AW'(0), 0);
    // offset spans the whole range: it must not wrap
    send_request(CW'(COORD_MIN), CW'(COORD_MIN), CW'(COORD_MAX), CW'(COORD_MAX),
                 AW'(-32768), 0);
    send_request(CW'(COORD_MAX), CW'(COORD_MIN), CW'(COORD_MIN), CW'(COORD_MAX),
                 AW'(16384), 0);
    send_request(CW'(0), CW'(0), CW'(0), CW'(0), AW'(0), 0);
    send_request(CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX),
                 AW'(12345), 0);
  endtask

  task automatic test_saturation();
    send_request(CW'(COORD_MAX), CW'(0), CW'(0), CW'(0), AW'(8192), 0);
    send_request(CW'(COORD_MAX), CW'(COORD_MAX), CW'(0), CW'(0), AW'(8192), 0);
    send_request(CW'(COORD_MIN), CW'(COORD_MAX), CW'(COORD_MAX), CW'(0), AW'(-24576), 0);
  endtask

  task automatic test_random_points();
    logic signed [CW-1:0] px, py, cx, cy;
    logic signed [AW-1:0] ang;
    int                   kind, gap;
    logic                 idling;
    idling = 1'b0;
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      // switch between bursty and back-to-back stretches
      if (n % 64 == 0) idling = $urandom_range(0, 1);
      kind = $urandom_range(0, 9);
      kind = (kind < 5) ? 0 : (kind < 7) ? 1 : 2;
      px = pick_coord(kind);
      py = pick_coord(kind);
      if ($urandom_range(0, 3) == 0) begin
        cx = pick_coord(2);
        cy = pick_coord(2);
      end else begin
        cx = pick_coord(kind);
        cy = pick_coord(kind);
      end
      if ($urandom_range(0, 7) == 0)
        ang = AW'($urandom_range(0, 7) * 8192 + $urandom_range(0, 2) - 1);
      else
        ang = AW'($urandom);
      gap = 0;
      if (idling && n < RANDOM_POINTS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        gap = $urandom_range(1, 15);
      send_request(px, py, cx, cy, ang, gap);
    end
  endtask

  always @(posedge clk) begin
    rotated_point_t exp_pt;
    if (!rst && done) begin
      if (rotated_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d sat=%0b",
                   rotated_x, rotated_y, saturated);
      end else begin
        exp_pt = rotated_q.pop_front();
        if (rotated_x !== exp_pt.x || rotated_y !== exp_pt.y || saturated !== exp_pt.sat)
        begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: expected x=%0d y=%0d sat=%0b, got x=%0d y=%0d sat=%0b",
                     exp_pt.x, exp_pt.y, exp_pt.sat, rotated_x, rotated_y, saturated);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    mismatch_count = 0;
    rst        <= 1'b1;
    start      <= 1'b0;
    point_x    <= '0;
    point_y    <= '0;
    center_x   <= '0;
    center_y   <= '0;
    turn_angle <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_angle_extremes();
    test_coord_extremes();
    test_saturation();
    test_random_points();

    start <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
rtl/prac_pkg.sv
rtl/point_rotate_about_center_unit.sv
rtl/prac_check.sv
dv/tb_point_rotate_about_center_unit.sv
